@@ hdl/nearest_palette_color_macros.svh @@
// Assertion macros for the nearest palette color checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef NEAREST_PALETTE_COLOR_MACROS_SVH
`define NEAREST_PALETTE_COLOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define NPC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define NPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/npc_pkg.sv @@
// Shared types and constants for the nearest palette color block.
// No dependencies; imported by npc_ctrl, npc_dpath and the top level.
`default_nettype none

package npc_pkg;

  // Default palette depth
  localparam int unsigned ENTRIES_DEF = 256;

  // Field widths
  localparam int unsigned COLOR_W = 8;
  localparam int unsigned INDEX_W = 8;
  localparam int unsigned DIST_W  = 18;
  localparam int unsigned MIN_W   = 24;
  localparam int unsigned SQ_W    = 2 * COLOR_W;

  // Running minimum starts above any real distance
  localparam logic [MIN_W-1:0] START_MIN = 24'h800000;

  // Item function codes
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic clr_en;     // write zero at the sweep counter, advance
    logic wr_item;    // store the incoming palette entry
    logic scan_init;  // capture query color, restart counter and minimum
    logic scan_en;    // read one entry, advance
    logic out_load;   // move the final minimum into the output register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic cnt_last;   // counter sits on the last entry
    logic pipe_busy;  // a read or a distance is still in flight
  } sts_t;

endpackage

`default_nettype wire

@@ hdl/npc_ctrl.sv @@
// Controller for the nearest palette color block: clear sweep, item
// handshake, scan sequencing and output register valid. Uses npc_pkg.
`default_nettype none

module npc_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic          func_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  input  wire npc_pkg::sts_t sts_i,
  output npc_pkg::cmd_t      cmd_o
);
  import npc_pkg::*;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;

  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign in_ready_o = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  // Commands decoded from state
  always_comb begin
    cmd_o           = '0;
    cmd_o.clr_en    = (state_q == ST_CLEAR);
    cmd_o.wr_item   = accept && (func_i == FUNC_WRITE);
    cmd_o.scan_init = accept && (func_i == FUNC_QUERY);
    cmd_o.scan_en   = (state_q == ST_SCAN);
    cmd_o.out_load  = (state_q == ST_DRAIN) && !sts_i.pipe_busy &&
                      (!out_valid_q || out_ready_i);
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (sts_i.cnt_last) state_d = ST_IDLE;
      ST_IDLE:  if (cmd_o.scan_init) state_d = ST_SCAN;
      ST_SCAN:  if (sts_i.cnt_last) state_d = ST_DRAIN;
      ST_DRAIN: if (cmd_o.out_load) state_d = ST_IDLE;
      default:  state_d = ST_CLEAR;
    endcase
  end

  // Output beat held until taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

@@ hdl/npc_dpath.sv @@
// Datapath for the nearest palette color block: palette memory, sweep
// counter, distance pipeline, running minimum, output register. Uses npc_pkg.
`default_nettype none

module npc_dpath #(
  parameter int unsigned ENTRIES = npc_pkg::ENTRIES_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire npc_pkg::cmd_t                   cmd_i,
  output npc_pkg::sts_t                        sts_o,
  input  wire logic [npc_pkg::INDEX_W-1:0]     entry_index_i,
  input  wire logic [npc_pkg::COLOR_W-1:0]     red_i,
  input  wire logic [npc_pkg::COLOR_W-1:0]     green_i,
  input  wire logic [npc_pkg::COLOR_W-1:0]     blue_i,
  output logic      [npc_pkg::INDEX_W-1:0]     best_index_o,
  output logic      [npc_pkg::DIST_W-1:0]      best_distance_o
);
  import npc_pkg::*;

  localparam int unsigned AW  = $clog2(ENTRIES);
  localparam int unsigned ENT_W = 3 * COLOR_W;

  // Palette memory, single port
  logic [ENT_W-1:0] mem [ENTRIES];
  logic [ENT_W-1:0] rdata_q;
  logic [AW-1:0]    mem_addr;
  logic             mem_we;
  logic [ENT_W-1:0] mem_wdata;

  // Sweep counter
  logic [AW-1:0] cnt_q, cnt_d;
  logic          cnt_last;

  // Query color
  logic [COLOR_W-1:0] qr_q, qg_q, qb_q;

  // Pipeline stages
  logic            s1_q, s2_q;
  logic [AW-1:0]   idx1_q, idx2_q;
  logic [SQ_W-1:0] sqr_q, sqg_q, sqb_q;

  // Running minimum
  logic [MIN_W-1:0] min_q;
  logic [AW-1:0]    best_q;

  // Output register
  logic [INDEX_W-1:0] out_idx_q;
  logic [DIST_W-1:0]  out_dist_q;

  logic [31:0]        widx;
  logic               wr_in_range;
  logic [COLOR_W-1:0] dr, dg, db;
  logic [DIST_W-1:0]  cand_dist;
  logic [31:0]        best_wide;

  assign cnt_last = (cnt_q == AW'(ENTRIES - 1));
  assign sts_o.cnt_last  = cnt_last;
  assign sts_o.pipe_busy = s1_q || s2_q;

  // Write address and range check
  assign widx        = 32'(entry_index_i);
  assign wr_in_range = (widx < 32'(ENTRIES));

  // Port arbitration: clear sweep, item write, else scan read
  always_comb begin
    mem_addr  = cnt_q;
    mem_we    = 1'b0;
    mem_wdata = '0;
    if (cmd_i.clr_en) begin
      mem_we = 1'b1;
    end else if (cmd_i.wr_item) begin
      mem_addr  = widx[AW-1:0];
      mem_we    = wr_in_range;
      mem_wdata = {red_i, green_i, blue_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rdata_q <= mem[mem_addr];
  end

  // Counter advance, wraps after the last entry
  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.scan_init) begin
      cnt_d = '0;
    end else if (cmd_i.clr_en || cmd_i.scan_en) begin
      cnt_d = cnt_last ? '0 : cnt_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      s1_q  <= 1'b0;
      s2_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      s1_q  <= cmd_i.scan_en;
      s2_q  <= s1_q;
    end
  end

  // Stage 1: absolute differences and squares
  assign dr = (qr_q >= rdata_q[23:16]) ? qr_q - rdata_q[23:16] : rdata_q[23:16] - qr_q;
  assign dg = (qg_q >= rdata_q[15:8])  ? qg_q - rdata_q[15:8]  : rdata_q[15:8] - qg_q;
  assign db = (qb_q >= rdata_q[7:0])   ? qb_q - rdata_q[7:0]   : rdata_q[7:0] - qb_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_init) begin
      qr_q <= red_i;
      qg_q <= green_i;
      qb_q <= blue_i;
    end
    if (cmd_i.scan_en) begin
      idx1_q <= cnt_q;
    end
    if (s1_q) begin
      sqr_q  <= SQ_W'(dr) * SQ_W'(dr);
      sqg_q  <= SQ_W'(dg) * SQ_W'(dg);
      sqb_q  <= SQ_W'(db) * SQ_W'(db);
      idx2_q <= idx1_q;
    end
  end

  // Stage 2: sum and strict compare, ties keep the lower index
  assign cand_dist = DIST_W'(sqr_q) + DIST_W'(sqg_q) + DIST_W'(sqb_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_init) begin
      min_q  <= START_MIN;
      best_q <= '0;
    end else if (s2_q && (MIN_W'(cand_dist) < min_q)) begin
      min_q  <= MIN_W'(cand_dist);
      best_q <= idx2_q;
    end
  end

  // Output register, low byte of the winning index
  assign best_wide = 32'(best_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_idx_q  <= best_wide[INDEX_W-1:0];
      out_dist_q <= min_q[DIST_W-1:0];
    end
  end

  assign best_index_o    = out_idx_q;
  assign best_distance_o = out_dist_q;

endmodule

`default_nettype wire

@@ hdl/nearest_palette_color.sv @@
// Nearest palette color search. Input channel carries write and query
// items, output channel carries one result beat per query.
// Write item (func 0): stores red/green/blue at entry_index;
//   no result beat; an index at or beyond ENTRIES is dropped.
// Query item (func 1): scans the palette from entry 0 upward, one entry per
//   cycle through the single-port palette memory, then through the pipeline
//   stages for squares and compare. Result beat: best_index (lowest index on ties)
//   and its squared distance.
// Busy: a query keeps in_ready_o low while it scans and until its result
//   is loaded into the output register; after a write in_ready_o stays
//   high for the next item.
// Reset: the palette is zeroed by a sweep, one entry per cycle; in_ready_o
//   stays low until it completes.
// Stall: the result sits in an output register until taken; the block keeps
//   taking items meanwhile, and a finished query waits at its end of scan
//   until the previous beat is taken.
// Depends on npc_pkg, npc_ctrl and npc_dpath.
`default_nettype none

module nearest_palette_color #(
  parameter int unsigned ENTRIES = npc_pkg::ENTRIES_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic                        func_i,
  input  wire logic [npc_pkg::INDEX_W-1:0] entry_index_i,
  input  wire logic [npc_pkg::COLOR_W-1:0] red_i,
  input  wire logic [npc_pkg::COLOR_W-1:0] green_i,
  input  wire logic [npc_pkg::COLOR_W-1:0] blue_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic      [npc_pkg::INDEX_W-1:0] best_index_o,
  output logic      [npc_pkg::DIST_W-1:0]  best_distance_o
);
  import npc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  npc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .func_i      (func_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  npc_dpath #(
    .ENTRIES (ENTRIES)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .entry_index_i   (entry_index_i),
    .red_i           (red_i),
    .green_i         (green_i),
    .blue_i          (blue_i),
    .best_index_o    (best_index_o),
    .best_distance_o (best_distance_o)
  );

endmodule

`default_nettype wire

@@ hdl/nearest_palette_color_chk.sv @@
// Port-level checker for nearest_palette_color, bound to the top level.
// Depends on npc_pkg and nearest_palette_color_macros.svh.
`default_nettype none

`include "nearest_palette_color_macros.svh"

module nearest_palette_color_chk (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_valid_i,
  input wire logic                        in_ready_o,
  input wire logic                        func_i,
  input wire logic [npc_pkg::INDEX_W-1:0] entry_index_i,
  input wire logic [npc_pkg::COLOR_W-1:0] red_i,
  input wire logic [npc_pkg::COLOR_W-1:0] green_i,
  input wire logic [npc_pkg::COLOR_W-1:0] blue_i,
  input wire logic                        out_valid_o,
  input wire logic                        out_ready_i,
  input wire logic [npc_pkg::INDEX_W-1:0] best_index_o,
  input wire logic [npc_pkg::DIST_W-1:0]  best_distance_o
);
  import npc_pkg::*;

  localparam logic [DIST_W-1:0] MAX_DIST = 18'd195075;

  logic in_beat;
  logic unused_ok;

  assign in_beat   = in_valid_i && in_ready_o;
  assign unused_ok = ^{entry_index_i, red_i, green_i, blue_i};

  // Stalled result beat holds
  `NPC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i,
    out_valid_o && $stable(best_index_o) && $stable(best_distance_o),
    "result beat changed while stalled")

  // A query blocks the input while it scans
  `NPC_ASSERT_NEXT(a_query_busy, clk_i, rst_ni, in_beat && (func_i == FUNC_QUERY),
    !in_ready_o, "input ready right after a query beat")

  // A write leaves the input ready in the next cycle
  `NPC_ASSERT_NEXT(a_write_fast, clk_i, rst_ni, in_beat && (func_i == FUNC_WRITE),
    in_ready_o, "input not ready right after a write beat")

  // A new result only comes from a running query
  `NPC_ASSERT_NOW(a_out_from_scan, clk_i, rst_ni, $rose(out_valid_o),
    $past(!in_ready_o), "result appeared while idle")

  // Distance never exceeds three full-scale squares
  `NPC_ASSERT_NOW(a_dist_range, clk_i, rst_ni, out_valid_o && (unused_ok || !unused_ok),
    best_distance_o <= MAX_DIST, "distance out of range")

endmodule

bind nearest_palette_color nearest_palette_color_chk u_chk (.*);

`default_nettype wire

@@ tb/sv/tb.sv @@
// Self-checking testbench for nearest_palette_color: palette writes and
// nearest-color queries checked against a palette mirror held in a scoreboard.
// Depends on npc_pkg and the nearest_palette_color RTL.
module tb;
  import npc_pkg::*;

  localparam int unsigned ENTRIES     = ENTRIES_DEF;
  localparam int unsigned PHASES      = 6;
  localparam int unsigned PHASE_ITEMS = 240;

  typedef struct packed {
    logic [INDEX_W-1:0] index;
    logic [DIST_W-1:0]  distance;
  } color_match_t;

  // Palette mirror plus the queue of nearest-color answers still owed
  class palette_tracker;
    logic [3*COLOR_W-1:0] palette [ENTRIES];
    color_match_t         pending_matches [$];
    int unsigned          mismatches;
    int unsigned          checked;

    function new();
      for (int unsigned i = 0; i < ENTRIES; i++) palette[i] = '0;
      mismatches = 0;
      checked    = 0;
    endfunction

    function int unsigned sq_gap(logic [COLOR_W-1:0] a, logic [COLOR_W-1:0] b);
      int unsigned d;
      d = (a >= b) ? int'(a - b) : int'(b - a);
      return d * d;
    endfunction

    // Full scan, strict less-than so ties keep the lowest index
    function color_match_t find_nearest(logic [COLOR_W-1:0] r, logic [COLOR_W-1:0] g,
                                        logic [COLOR_W-1:0] b);
      color_match_t m;
      int unsigned  low_mark;
      int unsigned  best_i;
      int unsigned  gap_sum;
      low_mark = START_MIN;
      best_i   = 0;
      for (int unsigned i = 0; i < ENTRIES; i++) begin
        gap_sum = sq_gap(r, palette[i][23:16]) + sq_gap(g, palette[i][15:8])
                + sq_gap(b, palette[i][7:0]);
        if (gap_sum < low_mark) begin
          low_mark = gap_sum;
          best_i   = i;
        end
      end
      m.index    = best_i[INDEX_W-1:0];
      m.distance = low_mark[DIST_W-1:0];
      return m;
    endfunction

    function void note_item(logic f, logic [INDEX_W-1:0] idx, logic [COLOR_W-1:0] r,
                            logic [COLOR_W-1:0] g, logic [COLOR_W-1:0] b);
      if (f == FUNC_WRITE) begin
        if (idx < ENTRIES) palette[idx] = {r, g, b};
      end else begin
        pending_matches.push_back(find_nearest(r, g, b));
      end
    endfunction

    function void check_match(logic [INDEX_W-1:0] idx, logic [DIST_W-1:0] distance);
      color_match_t want;
      if (pending_matches.size() == 0) begin
        mismatches++;
        $display("%0t: result beat with nothing expected: index %0d distance %0d",
                 $time, idx, distance);
        return;
      end
      want = pending_matches.pop_front();
      checked++;
      if (want.index !== idx) begin
        mismatches++;
        $display("%0t: best_index expected %0d actual %0d", $time, want.index, idx);
      end
      if (want.distance !== distance) begin
        mismatches++;
        $display("%0t: best_distance expected %0d actual %0d", $time, want.distance,
                 distance);
      end
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic                 func_i;
  logic [INDEX_W-1:0]   entry_index_i;
  logic [COLOR_W-1:0]   red_i;
  logic [COLOR_W-1:0]   green_i;
  logic [COLOR_W-1:0]   blue_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [INDEX_W-1:0]   best_index_o;
  logic [DIST_W-1:0]    best_distance_o;

  palette_tracker board = new();
  int unsigned    send_gap = 0;
  int unsigned    writes_sent = 0;
  int unsigned    queries_sent = 0;
  bit             tx_steady = 1'b0;
  bit             rx_steady = 1'b0;

  nearest_palette_color #(.ENTRIES(ENTRIES)) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .func_i         (func_i),
    .entry_index_i  (entry_index_i),
    .red_i          (red_i),
    .green_i        (green_i),
    .blue_i         (blue_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .best_index_o   (best_index_o),
    .best_distance_o(best_distance_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Safety net against a hung handshake
  initial begin
    #60_000_000;
    $display("** nearest_palette_color: FAILED **");
    $finish;
  end

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap(bit steady);
    int unsigned roll;
    if (steady) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  // Long stalls can outlast a whole scan so a finished query has to wait
  function automatic int unsigned pick_stall(bit steady);
    int unsigned roll;
    if (steady) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 4);
    if (roll < 97) return $urandom_range(5, 40);
    return $urandom_range(100, 600);
  endfunction

  function automatic logic [COLOR_W-1:0] coarse_level();
    case ($urandom_range(0, 3))
      0:       return 8'd0;
      1:       return 8'd64;
      2:       return 8'd128;
      default: return 8'd255;
    endcase
  endfunction

  function automatic logic [COLOR_W-1:0] nudge(logic [COLOR_W-1:0] v);
    int t;
    t = int'(v) + int'($urandom_range(0, 16)) - 8;
    if (t < 0) t = 0;
    if (t > 255) t = 255;
    return t[COLOR_W-1:0];
  endfunction

  // One input beat; valid stays up into the next beat when no gap follows
  task automatic send_item(logic f, logic [INDEX_W-1:0] idx, logic [COLOR_W-1:0] r,
                           logic [COLOR_W-1:0] g, logic [COLOR_W-1:0] b);
    repeat (send_gap) @(posedge clk_i);
    in_valid_i    <= 1'b1;
    func_i        <= f;
    entry_index_i <= idx;
    red_i         <= r;
    green_i       <= g;
    blue_i        <= b;
    @(posedge clk_i);
    while (in_ready_o !== 1'b1) @(posedge clk_i);
    board.note_item(f, idx, r, g, b);
    if (f == FUNC_WRITE) writes_sent++;
    else queries_sent++;
    send_gap = pick_gap(tx_steady);
    if (send_gap != 0) in_valid_i <= 1'b0;
  endtask

  task automatic hold_sender();
    if (send_gap == 0) in_valid_i <= 1'b0;
    send_gap = 1;
  endtask

  task automatic wait_for_matches();
    while (board.pending_matches.size() != 0) @(posedge clk_i);
  endtask

  // Random beat; kind picks full-range, coarse (tie-heavy) or near-entry colors
  task automatic random_item(int unsigned kind);
    logic                 f;
    logic [INDEX_W-1:0]   idx;
    logic [COLOR_W-1:0]   r, g, b;
    logic [3*COLOR_W-1:0] near;
    f   = ($urandom_range(0, 1) == 1) ? FUNC_QUERY : FUNC_WRITE;
    idx = INDEX_W'($urandom);
    r   = COLOR_W'($urandom);
    g   = COLOR_W'($urandom);
    b   = COLOR_W'($urandom);
    if (kind == 1) begin
      r = coarse_level();
      g = coarse_level();
      b = coarse_level();
    end else if (kind == 2 && f == FUNC_QUERY) begin
      near = board.palette[$urandom_range(0, ENTRIES - 1)];
      r    = nudge(near[23:16]);
      g    = nudge(near[15:8]);
      b    = nudge(near[7:0]);
    end
    send_item(f, idx, r, g, b);
  endtask

  // Directed: cleared palette, extreme colors, ties toward the lowest index
  task automatic run_directed();
    send_item(FUNC_QUERY, 8'hFF, 8'h00, 8'h00, 8'h00);
    send_item(FUNC_QUERY, 8'h00, 8'hFF, 8'hFF, 8'hFF);
    send_item(FUNC_WRITE, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_item(FUNC_QUERY, 8'h00, 8'hFF, 8'hFF, 8'hFF);
    send_item(FUNC_WRITE, 8'h80, 8'hFF, 8'hFF, 8'hFF);
    send_item(FUNC_QUERY, 8'h5A, 8'hFA, 8'hFF, 8'hFF);
    send_item(FUNC_WRITE, 8'h00, 8'h0A, 8'h14, 8'h1E);
    send_item(FUNC_QUERY, 8'hA5, 8'h0A, 8'h14, 8'h1E);
    send_item(FUNC_QUERY, 8'h00, 8'h00, 8'h00, 8'h00);
    send_item(FUNC_WRITE, 8'h07, 8'h55, 8'hAA, 8'h0F);
    send_item(FUNC_WRITE, 8'hC8, 8'hAA, 8'h55, 8'hF0);
    send_item(FUNC_QUERY, 8'h00, 8'h55, 8'hAA, 8'h0F);
    send_item(FUNC_QUERY, 8'hFF, 8'hAA, 8'h55, 8'hF0);
    send_item(FUNC_WRITE, 8'h80, 8'h00, 8'h00, 8'h00);
    send_item(FUNC_QUERY, 8'h00, 8'hFF, 8'hFF, 8'hFF);
    send_item(FUNC_QUERY, 8'h00, 8'hFF, 8'h00, 8'h00);
    send_item(FUNC_QUERY, 8'h00, 8'h00, 8'hFF, 8'h00);
    send_item(FUNC_QUERY, 8'h00, 8'h00, 8'h00, 8'hFF);
    send_item(FUNC_WRITE, 8'h01, 8'h00, 8'h00, 8'h00);
    send_item(FUNC_QUERY, 8'h33, 8'h01, 8'h01, 8'h01);
  endtask

  // Result side: check each taken beat, then choose the next ready level
  initial begin
    bit          took;
    int unsigned stall_left;
    logic        ready_n;
    out_ready_i <= 1'b0;
    stall_left  = 0;
    forever begin
      @(posedge clk_i);
      took = (out_valid_o === 1'b1) && (out_ready_i === 1'b1);
      if (took) begin
        board.check_match(best_index_o, best_distance_o);
        stall_left = pick_stall(rx_steady);
      end else if (!rx_steady && stall_left == 0 && $urandom_range(0, 39) == 0) begin
        stall_left = $urandom_range(1, 30);
      end
      if (stall_left > 0) begin
        stall_left--;
        ready_n = 1'b0;
      end else begin
        ready_n = 1'b1;
      end
      out_ready_i <= ready_n;
    end
  end

  // Stimulus: reset, directed beats, then random phases with a drain after each
  initial begin
    rst_ni        <= 1'b0;
    in_valid_i    <= 1'b0;
    func_i        <= FUNC_WRITE;
    entry_index_i <= '0;
    red_i         <= '0;
    green_i       <= '0;
    blue_i        <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    run_directed();
    hold_sender();
    wait_for_matches();

    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      tx_steady = (phase == 1);
      rx_steady = (phase == 1) || (phase == 4);
      for (int unsigned n = 0; n < PHASE_ITEMS; n++) random_item(phase % 3);
      hold_sender();
      wait_for_matches();
    end

    repeat (ENTRIES + 8) @(posedge clk_i);
    $display("Run covered %0d palette writes and %0d nearest-color queries, %0d results checked.",
             writes_sent, queries_sent, board.checked);
    $display("Included cleared palette, extreme colors, tie-heavy and near-entry queries, stalls.");
    if (board.mismatches == 0 && board.pending_matches.size() == 0) begin
      $display("** nearest_palette_color: PASSED **");
    end else begin
      $display("** nearest_palette_color: FAILED **");
    end
    $finish;
  end
endmodule
